FILE: hw/rtl/rmpt_pkg.sv
// Shared types and constants for the rate monotonic priority table.
package rmpt_pkg;

  localparam int TASK_W   = 3;
  localparam int EXEC_W   = 16;
  localparam int DLY_W    = 8;
  localparam int PERIOD_W = 19;
  localparam int CNT_W    = 4;
  localparam int RANK_W   = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] MS_PER_SECOND = PERIOD_W'(1000);
  localparam logic [CNT_W-1:0]    MAX_LIST      = CNT_W'(8);

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_LIST
  } state_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [TASK_W-1:0]     new_task;
    logic [PERIOD_W-1:0]   new_period;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/rmpt_cell.sv
// One rank of the sorted task table; trades entries with its neighbors.
module rmpt_cell
  import rmpt_pkg::*;
#(
  parameter int DEPTH    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  logic [$clog2(DEPTH)-1:0]   pos,
  input  logic                       left_gt,
  input  logic [TASK_W-1:0]          left_task,
  input  logic [PERIOD_W-1:0]        left_period,
  input  logic [TASK_W-1:0]          right_task,
  input  logic [PERIOD_W-1:0]        right_period,
  input  logic [TASK_W-1:0]          head_task,
  input  logic [PERIOD_W-1:0]        head_period,
  output logic [TASK_W-1:0]          task_o,
  output logic [PERIOD_W-1:0]        period_o,
  output logic                       gt_o,
  output logic                       match_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [CMP_W-1:0] IDX_C = CMP_W'(CELL_IDX);

  logic [TASK_W-1:0]   task_r, task_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [CMP_W-1:0]    count_ext;
  logic                occupied;
  logic                is_tail;
  logic                past_pos;

  assign count_ext = CMP_W'(ctrl.count);
  assign occupied  = IDX_C < count_ext;
  assign is_tail   = (IDX_C + CMP_W'(1)) == count_ext;
  assign past_pos  = IDX_C >= CMP_W'(pos);

  assign gt_o     = occupied && (period_r > ctrl.new_period);
  assign match_o  = occupied && (task_r == ctrl.new_task);
  assign task_o   = task_r;
  assign period_o = period_r;

  always_comb begin
    task_nxt   = task_r;
    period_nxt = period_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        // Entries with a longer period slide right; the first free or
        // longer slot that is not fed from the left takes the new task.
        if (left_gt) begin
          task_nxt   = left_task;
          period_nxt = left_period;
        end else if (gt_o || !occupied) begin
          task_nxt   = ctrl.new_task;
          period_nxt = ctrl.new_period;
        end
      end
      CMD_REMOVE: begin
        if (past_pos) begin
          task_nxt   = right_task;
          period_nxt = right_period;
        end
      end
      CMD_ROTATE: begin
        // The head wraps around to the last occupied rank.
        if (is_tail) begin
          task_nxt   = head_task;
          period_nxt = head_period;
        end else begin
          task_nxt   = right_task;
          period_nxt = right_period;
        end
      end
      default: begin
        task_nxt   = task_r;
        period_nxt = period_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    task_r   <= task_nxt;
    period_r <= period_nxt;
  end

endmodule

FILE: hw/rtl/rate_monotonic_priority_table_core.sv
// Rate monotonic priority table: a row of rank cells and the toggle sequencer.
// A toggle is taken in idle, searched, applied to the row of cells in the next
// cycle, then listed one result per cycle (unless out_tready stalls) by rotating
// the row past rank 0. The list holds max(1, active tasks) results, and a new
// toggle is only taken back in idle, once the last result has been loaded.
// Synchronous active-low reset empties the table at once; no clearing pass.
module rate_monotonic_priority_table_core
  import rmpt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] task_id, [18:3] exec_time_ms, [26:19] delay_seconds
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] rank, [5:3] entry_task, [24:6] entry_period, [25] was_added,
  // [29:26] active_total
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] entry_valid
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

  state_t              state_r, state_nxt;
  logic [TASK_W-1:0]   id_r, id_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic                added_r, added_nxt;
  logic [RANK_W-1:0]   list_idx_r, list_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]   o_rank_r, o_rank_nxt;
  logic [TASK_W-1:0]   o_task_r, o_task_nxt;
  logic [PERIOD_W-1:0] o_period_r, o_period_nxt;
  logic                o_entry_r, o_entry_nxt;
  logic                o_added_r, o_added_nxt;
  logic [CNT_W-1:0]    o_total_r, o_total_nxt;
  logic                o_last_r, o_last_nxt;

  logic                in_fire;
  logic                load_en;
  logic                table_full;
  logic                list_last;
  logic                found_c;
  logic [IDX_W-1:0]    pos_c;
  cell_ctrl_t          ctrl;
  cell_cmd_t           cmd;

  logic [TASK_W-1:0]      c_task   [TABLE_DEPTH];
  logic [PERIOD_W-1:0]    c_period [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] c_gt;
  logic [TABLE_DEPTH-1:0] c_match;

  assign in_fire    = in_tvalid && in_tready;
  assign table_full = CMP_W'(count_r) >= DEPTH_C;
  assign list_last  = (count_r == '0) ||
                      ((CNT_W'(list_idx_r) + CNT_W'(1)) == count_r);

  // Ids are unique among occupied ranks, so at most one match bit is set.
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (c_match[i]) begin
        pos_c = pos_c | IDX_W'(i);
      end
    end
  end
  assign found_c = |c_match;

  assign ctrl.cmd        = cmd;
  assign ctrl.new_task   = id_r;
  assign ctrl.new_period = per_r;
  assign ctrl.count      = count_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                lgt;
    logic [TASK_W-1:0]   ltask, rtask;
    logic [PERIOD_W-1:0] lper, rper;

    if (g == 0) begin : g_first
      assign lgt   = 1'b0;
      assign ltask = c_task[0];
      assign lper  = c_period[0];
    end else begin : g_mid
      assign lgt   = c_gt[g-1];
      assign ltask = c_task[g-1];
      assign lper  = c_period[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_end
      assign rtask = c_task[0];
      assign rper  = c_period[0];
    end else begin : g_inner
      assign rtask = c_task[g+1];
      assign rper  = c_period[g+1];
    end

    rmpt_cell #(
      .DEPTH    (TABLE_DEPTH),
      .CELL_IDX (g)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .pos          (pos_r),
      .left_gt      (lgt),
      .left_task    (ltask),
      .left_period  (lper),
      .right_task   (rtask),
      .right_period (rper),
      .head_task    (c_task[0]),
      .head_period  (c_period[0]),
      .task_o       (c_task[g]),
      .period_o     (c_period[g]),
      .gt_o         (c_gt[g]),
      .match_o      (c_match[g])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_LIST;
      ST_LIST: begin
        if (load_en && list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready = 1'b0;
    load_en   = 1'b0;
    cmd       = CMD_HOLD;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SEARCH: cmd = CMD_HOLD;
      ST_UPDATE: begin
        if (found_r) begin
          cmd = CMD_REMOVE;
        end else if (!table_full) begin
          cmd = CMD_INSERT;
        end
      end
      ST_LIST: begin
        load_en = !out_valid_r || out_tready;
        if (load_en && (count_r != '0)) begin
          cmd = CMD_ROTATE;
        end
      end
      default: begin
        in_tready = 1'b0;
        load_en   = 1'b0;
        cmd       = CMD_HOLD;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    id_nxt       = id_r;
    per_nxt      = per_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    added_nxt    = added_r;
    list_idx_nxt = list_idx_r;

    if (in_fire) begin
      id_nxt  = in_tdata[2:0];
      per_nxt = PERIOD_W'(in_tdata[18:3]) + PERIOD_W'(in_tdata[26:19]) * MS_PER_SECOND;
    end
    if (state_r == ST_SEARCH) begin
      found_nxt = found_c;
      pos_nxt   = pos_c;
    end
    if (state_r == ST_UPDATE) begin
      list_idx_nxt = '0;
      added_nxt    = 1'b0;
      if (cmd == CMD_REMOVE) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (cmd == CMD_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
        added_nxt = 1'b1;
      end
    end
    if (load_en) begin
      list_idx_nxt = list_idx_r + RANK_W'(1);
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_rank_nxt    = o_rank_r;
    o_task_nxt    = o_task_r;
    o_period_nxt  = o_period_r;
    o_entry_nxt   = o_entry_r;
    o_added_nxt   = o_added_r;
    o_total_nxt   = o_total_r;
    o_last_nxt    = o_last_r;

    if (load_en) begin
      out_valid_nxt = 1'b1;
      o_rank_nxt    = list_idx_r;
      o_added_nxt   = added_r;
      o_total_nxt   = count_r;
      o_last_nxt    = list_last;
      if (count_r == '0) begin
        // Empty table: a single marker with no entry.
        o_task_nxt   = '0;
        o_period_nxt = '0;
        o_entry_nxt  = 1'b0;
      end else begin
        o_task_nxt   = c_task[0];
        o_period_nxt = c_period[0];
        o_entry_nxt  = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      added_r     <= 1'b0;
      list_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      added_r     <= added_nxt;
      list_idx_r  <= list_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    per_r      <= per_nxt;
    pos_r      <= pos_nxt;
    o_rank_r   <= o_rank_nxt;
    o_task_r   <= o_task_nxt;
    o_period_r <= o_period_nxt;
    o_entry_r  <= o_entry_nxt;
    o_added_r  <= o_added_nxt;
    o_total_r  <= o_total_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_entry_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_total_r, o_added_r, o_period_r, o_task_r, o_rank_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= MAX_LIST) && (CMP_W'(count_r) <= DEPTH_C))
    else $error("active task count out of range");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && found_r) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("removal did not shrink the table");

  a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_entry_r) |-> (o_last_r && o_total_r == '0 && o_rank_r == '0))
    else $error("empty marker is not a lone final result");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_entry_r) |-> (CNT_W'(o_rank_r) < o_total_r))
    else $error("listed rank beyond active total");

endmodule
